### rtl/core/asdq_pkg.sv
// package with widths, register codes and shared types of the disconnect qualifier
`default_nettype none

package asdq_pkg;

  localparam int SAMPLES    = 5;
  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 14;
  localparam int CNT_W      = $clog2(SAMPLES + 1);
  localparam int SUSP_W     = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int VALUE_W    = 11;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int DIV_SHIFT  = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((2 ** DIV_SHIFT) + SAMPLES - 1) / SAMPLES);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PULLUP = 1'b1;

  localparam logic MODE_DROP = 1'b0;
  localparam logic MODE_TURB = 1'b1;

  localparam logic [VALUE_W-1:0] VALUE_NOT_CONNECTED = '1;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_SPREAD_THR,
    REG_RAW_HIGH_THR,
    REG_PULLUP_HIGH_THR,
    REG_PULLUP_DELTA_THR,
    REG_CONFIRM_COUNT
  } reg_idx_t;

  localparam logic                RST_MODE          = MODE_TURB;
  localparam logic [SAMPLE_W-1:0] RST_SPREAD_THR    = 10'd220;
  localparam logic [SAMPLE_W-1:0] RST_RAW_HIGH_THR  = 10'd850;
  localparam logic [SAMPLE_W-1:0] RST_PULLUP_HIGH   = 10'd1015;
  localparam logic [SAMPLE_W-1:0] RST_PULLUP_DELTA  = 10'd450;
  localparam logic [SUSP_W-1:0]   RST_CONFIRM_COUNT = 3'd3;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] spread_thr;
    logic [SAMPLE_W-1:0] raw_high_thr;
    logic [SAMPLE_W-1:0] pullup_high_thr;
    logic [SAMPLE_W-1:0] pullup_delta_thr;
    logic [SUSP_W-1:0]   confirm_count;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
  } snap_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg;
    logic                bad;
    logic [SUSP_W-1:0]   suspect_nxt;
  } verdict_t;

endpackage

`default_nettype wire

### rtl/core/analog_sensor_disconnect_qualifier_unit.sv
// top level of the analog sensor disconnect qualifier
// Accepts one ADC sample per clock. Ordinary samples (tuser 0) build a
// snapshot of sum, minimum and maximum over the first SAMPLES samples; a
// pull-up sample (tuser 1) closes it and yields one result: the truncated
// average, or all ones with status set when the sensor looks disconnected.
// Each transaction passes an input register and, for pull-up samples, an
// output register, and a new sample can be taken every cycle; only a result
// waiting in the output register while another pull-up sample is pending
// stalls the input side. No clearing pass follows reset.
`default_nettype none

module analog_sensor_disconnect_qualifier_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [asdq_pkg::IN_TDATA_W-1:0]  in_tdata,   // sample[9:0], zeros
  input  wire logic [0:0]                      in_tuser,   // op
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [asdq_pkg::OUT_TDATA_W-1:0] out_tdata,  // value[10:0], zeros
  output logic      [0:0]                      out_tuser,  // status
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [asdq_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [asdq_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic      [asdq_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import asdq_pkg::*;

  cfg_t     cfg;
  verdict_t verdict;

  logic                in_valid_r;
  logic                in_op_r;
  logic [SAMPLE_W-1:0] in_sample_r;

  snap_t               snap_r;
  snap_t               snap_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [SUSP_W-1:0]   suspect_r;
  logic [SUSP_W-1:0]   suspect_nxt;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [VALUE_W-1:0]  out_value_nxt;
  logic                out_status_r;

  logic stage_go;
  logic in_xfer;

  asdq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  asdq_eval u_eval (
    .cfg           (cfg),
    .snap          (snap_r),
    .pullup_sample (in_sample_r),
    .suspect_cnt   (suspect_r),
    .verdict       (verdict)
  );

  assign stage_go  = in_valid_r &&
                     ((in_op_r == OP_SAMPLE) || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || stage_go;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    snap_nxt    = snap_r;
    count_nxt   = count_r;
    suspect_nxt = suspect_r;
    if (stage_go) begin
      if (in_op_r == OP_PULLUP) begin
        snap_nxt.sum = '0;
        snap_nxt.min = '1;
        snap_nxt.max = '0;
        count_nxt    = '0;
        suspect_nxt  = verdict.suspect_nxt;
      end else if (count_r < CNT_W'(SAMPLES)) begin
        snap_nxt.sum = snap_r.sum + SUM_W'(in_sample_r);
        if (in_sample_r < snap_r.min) begin
          snap_nxt.min = in_sample_r;
        end
        if (in_sample_r > snap_r.max) begin
          snap_nxt.max = in_sample_r;
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  assign out_value_nxt = verdict.bad ? VALUE_NOT_CONNECTED : VALUE_W'(verdict.avg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      snap_r.sum  <= '0;
      snap_r.min  <= '1;
      snap_r.max  <= '0;
      count_r     <= '0;
      suspect_r   <= '0;
    end else begin
      snap_r    <= snap_nxt;
      count_r   <= count_nxt;
      suspect_r <= suspect_nxt;
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (stage_go) begin
        in_valid_r <= 1'b0;
      end
      if (stage_go && (in_op_r == OP_PULLUP)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_op_r     <= in_tuser[0];
      in_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (stage_go && (in_op_r == OP_PULLUP)) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= verdict.bad;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_TDATA_W'(out_value_r);
  assign out_tuser[0] = out_status_r;

  a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_value_r == VALUE_NOT_CONNECTED)
    else $error("not-connected result without all-ones value");

  a_ok_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_status_r |-> !out_value_r[VALUE_W-1])
    else $error("ok result with negative value");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SAMPLES))
    else $error("snapshot sample count beyond snapshot length");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !stage_go |-> in_op_r == OP_PULLUP && out_valid_r && !out_tready)
    else $error("input stage stalled without a blocked result");

  a_snap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stage_go && in_op_r == OP_PULLUP |=> count_r == '0 && snap_r.sum == '0)
    else $error("snapshot not cleared after pull-up sample");

endmodule

`default_nettype wire

### rtl/core/asdq_regs.sv
// apb configuration registers of the disconnect qualifier
`default_nettype none

module asdq_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [asdq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [asdq_pkg::DATA_W-1:0] pwdata,
  output logic      [asdq_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output asdq_pkg::cfg_t                  cfg
);
  import asdq_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:             cfg_nxt.mode             = pwdata[0];
        REG_SPREAD_THR:       cfg_nxt.spread_thr       = pwdata[SAMPLE_W-1:0];
        REG_RAW_HIGH_THR:     cfg_nxt.raw_high_thr     = pwdata[SAMPLE_W-1:0];
        REG_PULLUP_HIGH_THR:  cfg_nxt.pullup_high_thr  = pwdata[SAMPLE_W-1:0];
        REG_PULLUP_DELTA_THR: cfg_nxt.pullup_delta_thr = pwdata[SAMPLE_W-1:0];
        REG_CONFIRM_COUNT:    cfg_nxt.confirm_count    = pwdata[SUSP_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= RST_MODE;
      cfg_r.spread_thr       <= RST_SPREAD_THR;
      cfg_r.raw_high_thr     <= RST_RAW_HIGH_THR;
      cfg_r.pullup_high_thr  <= RST_PULLUP_HIGH;
      cfg_r.pullup_delta_thr <= RST_PULLUP_DELTA;
      cfg_r.confirm_count    <= RST_CONFIRM_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:             prdata = DATA_W'(cfg_r.mode);
      REG_SPREAD_THR:       prdata = DATA_W'(cfg_r.spread_thr);
      REG_RAW_HIGH_THR:     prdata = DATA_W'(cfg_r.raw_high_thr);
      REG_PULLUP_HIGH_THR:  prdata = DATA_W'(cfg_r.pullup_high_thr);
      REG_PULLUP_DELTA_THR: prdata = DATA_W'(cfg_r.pullup_delta_thr);
      REG_CONFIRM_COUNT:    prdata = DATA_W'(cfg_r.confirm_count);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/asdq_eval.sv
// snapshot evaluation: average, spread and pull-up tests, confirmation count
`default_nettype none

module asdq_eval (
  input  asdq_pkg::cfg_t                    cfg,
  input  asdq_pkg::snap_t                   snap,
  input  wire logic [asdq_pkg::SAMPLE_W-1:0] pullup_sample,
  input  wire logic [asdq_pkg::SUSP_W-1:0]   suspect_cnt,
  output asdq_pkg::verdict_t                verdict
);
  import asdq_pkg::*;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] spread;
  logic [SAMPLE_W-1:0] delta;
  logic                noisy;
  logic                pullhi;
  logic                suspect;
  logic [SUSP_W-1:0]   susp_nxt;

  // divide by the snapshot length through a reciprocal multiply
  assign prod   = PROD_W'(snap.sum) * PROD_W'(DIV_RECIP);
  assign avg    = prod[DIV_SHIFT +: SAMPLE_W];

  assign spread = snap.max - snap.min;
  assign delta  = pullup_sample - avg;
  assign noisy  = (snap.max >= snap.min) && (spread >= cfg.spread_thr);
  assign pullhi = (pullup_sample >= cfg.pullup_high_thr) && (pullup_sample >= avg) &&
                  (delta >= cfg.pullup_delta_thr);
  assign suspect = noisy && pullhi && (avg >= cfg.raw_high_thr);

  always_comb begin
    susp_nxt = suspect_cnt;
    if (cfg.mode == MODE_TURB) begin
      if (!suspect) begin
        susp_nxt = '0;
      end else if (suspect_cnt < cfg.confirm_count) begin
        susp_nxt = suspect_cnt + SUSP_W'(1);
      end
    end
  end

  assign verdict.avg         = avg;
  assign verdict.suspect_nxt = susp_nxt;
  assign verdict.bad         = (cfg.mode == MODE_DROP) ? (noisy || pullhi)
                                                       : (susp_nxt >= cfg.confirm_count);

endmodule

`default_nettype wire

### test/analog_sensor_disconnect_qualifier_unit_tb.sv
// self-checking testbench of the disconnect qualifier: snapshot stimulus, register sweeps, stalls
`timescale 1ns / 1ps

module analog_sensor_disconnect_qualifier_unit_tb;
  import asdq_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 100;
  localparam int RANDOM_PHASES   = 12;
  localparam int FIRST_UNUSED_REG = REG_CONFIRM_COUNT + 1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } reading_t;

  class disconnect_checker;
    cfg_t                cfg;
    logic [SUM_W-1:0]    snap_sum;
    logic [SAMPLE_W-1:0] snap_min;
    logic [SAMPLE_W-1:0] snap_max;
    int unsigned         snap_count;
    logic [SUSP_W-1:0]   suspect_cnt;
    reading_t            expected_readings[$];
    int                  errors;
    int                  readings_seen;
    int                  disconnects_seen;
    int                  suspect_snapshots;

    function new();
      cfg = '{mode: RST_MODE, spread_thr: RST_SPREAD_THR, raw_high_thr: RST_RAW_HIGH_THR,
              pullup_high_thr: RST_PULLUP_HIGH, pullup_delta_thr: RST_PULLUP_DELTA,
              confirm_count: RST_CONFIRM_COUNT};
      clear_snapshot();
      suspect_cnt = '0;
      errors = 0;
      readings_seen = 0;
      disconnects_seen = 0;
      suspect_snapshots = 0;
    endfunction

    function void clear_snapshot();
      snap_sum = '0;
      snap_min = '1;
      snap_max = '0;
      snap_count = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_MODE:             cfg.mode = data[0];
        REG_SPREAD_THR:       cfg.spread_thr = data[SAMPLE_W-1:0];
        REG_RAW_HIGH_THR:     cfg.raw_high_thr = data[SAMPLE_W-1:0];
        REG_PULLUP_HIGH_THR:  cfg.pullup_high_thr = data[SAMPLE_W-1:0];
        REG_PULLUP_DELTA_THR: cfg.pullup_delta_thr = data[SAMPLE_W-1:0];
        REG_CONFIRM_COUNT:    cfg.confirm_count = data[SUSP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic op, logic [SAMPLE_W-1:0] s);
      int unsigned avg;
      bit          noisy;
      bit          pullhi;
      bit          bad;
      reading_t    r;
      if (op == OP_SAMPLE) begin
        if (snap_count < SAMPLES) begin
          snap_sum = snap_sum + s;
          if (s < snap_min) snap_min = s;
          if (s > snap_max) snap_max = s;
          snap_count++;
        end
        return;
      end
      avg = snap_sum / SAMPLES;
      noisy = (snap_max >= snap_min) && ((snap_max - snap_min) >= cfg.spread_thr);
      pullhi = (s >= cfg.pullup_high_thr) && (s >= avg) &&
               ((s - avg) >= cfg.pullup_delta_thr);
      if (cfg.mode == MODE_DROP) begin
        bad = noisy || pullhi;
      end else begin
        if (noisy && pullhi && avg >= cfg.raw_high_thr) begin
          suspect_snapshots++;
          if (suspect_cnt < cfg.confirm_count) suspect_cnt = suspect_cnt + 1'b1;
        end else begin
          suspect_cnt = '0;
        end
        bad = suspect_cnt >= cfg.confirm_count;
      end
      if (bad) begin
        r.value = VALUE_NOT_CONNECTED;
        r.status = 1'b1;
      end else begin
        r.value = VALUE_W'(avg);
        r.status = 1'b0;
      end
      expected_readings.push_back(r);
      clear_snapshot();
    endfunction

    function void check_reading(logic [OUT_TDATA_W-1:0] tdata, logic [0:0] tuser);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("unexpected result: value %0d status %0d",
               $signed(tdata[VALUE_W-1:0]), tuser[0]);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      readings_seen++;
      if (want.status) disconnects_seen++;
      if (tdata[VALUE_W-1:0] !== want.value) begin
        $error("value: expected %0d, actual %0d", $signed(want.value),
               $signed(tdata[VALUE_W-1:0]));
        errors++;
      end
      if (tuser[0] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, tuser[0]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // sample[9:0], zeros
  logic [0:0]             in_tuser;   // op
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // value[10:0], zeros
  logic [0:0]             out_tuser;  // status
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [ADDR_W-1:0]      cfg_paddr;
  logic [DATA_W-1:0]      cfg_pwdata;
  logic [DATA_W-1:0]      cfg_prdata;
  logic                   cfg_pready;

  disconnect_checker checker_h;
  bit                hold_off_req;
  int                burst_left;
  int                samples_sent;
  int                settings_used;
  int                cycle_count;

  analog_sensor_disconnect_qualifier_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("analog_sensor_disconnect_qualifier_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) checker_h.check_reading(out_tdata, out_tuser);
  end

  // receiver: stall style redrawn at random from four styles, long hold-off on request
  initial begin
    int cyc;
    int style;
    out_tready = 1'b0;
    cyc = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        if (cyc % 128 == 0) style = $urandom_range(0, 3);
        cyc++;
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= (cyc % 4 != 3);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic op, logic [SAMPLE_W-1:0] s);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, s};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    checker_h.note_sample(op, s);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_snapshot();
    int          n;
    int          centre;
    int          spread;
    int          v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) n = 0;
    else if (pick < 20) n = $urandom_range(1, SAMPLES - 1);
    else if (pick < 85) n = SAMPLES;
    else n = $urandom_range(SAMPLES + 1, SAMPLES + 4);
    centre = $urandom_range(0, 1023);
    case ($urandom_range(0, 3))
      0: spread = $urandom_range(0, 8);
      1: spread = $urandom_range(0, 300);
      2: spread = 1023;
      default: spread = $urandom_range(600, 1023);
    endcase
    for (int i = 0; i < n; i++) begin
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_item(OP_SAMPLE, SAMPLE_W'(v));
    end
    case ($urandom_range(0, 4))
      0, 1: v = $urandom_range(900, 1023);
      2: v = 1023;
      3: v = $urandom_range(0, 1023);
      default: v = centre;
    endcase
    send_item(OP_PULLUP, SAMPLE_W'(v));
  endtask

  task automatic write_reg(int unsigned idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(idx * 4);
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    checker_h.write_reg(idx, data);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_settings(logic mode, int spread, int raw, int high, int delta, int confirm);
    wait_idle();
    write_reg(REG_MODE, DATA_W'(mode));
    write_reg(REG_SPREAD_THR, DATA_W'(spread));
    write_reg(REG_RAW_HIGH_THR, DATA_W'(raw));
    write_reg(REG_PULLUP_HIGH_THR, DATA_W'(high));
    write_reg(REG_PULLUP_DELTA_THR, DATA_W'(delta));
    write_reg(REG_CONFIRM_COUNT, DATA_W'(confirm));
    write_reg(FIRST_UNUSED_REG + $urandom_range(0, 1), $urandom);
    settings_used++;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1023;
      2: return $urandom_range(0, 300);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  initial begin
    int phase_start;
    checker_h = new();
    hold_off_req = 1'b0;
    burst_left = 1;
    samples_sent = 0;
    settings_used = 1;
    cycle_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_SAMPLE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty snapshots at both extremes of the pull-up sample
    send_item(OP_PULLUP, 10'd0);
    send_item(OP_PULLUP, 10'd1023);
    // short snapshot, pull-up below the average
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_PULLUP, 10'd0);
    // full snapshot plus ignored extra samples
    send_item(OP_SAMPLE, 10'd0);
    repeat (4) send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd512);
    send_item(OP_SAMPLE, 10'd0);
    send_item(OP_PULLUP, 10'd1023);

    // turbidity confirmation: suspect snapshots saturate the counter
    load_settings(MODE_TURB, 200, 600, 1000, 300, 2);
    repeat (3) begin
      repeat (3) send_item(OP_SAMPLE, 10'd1023);
      send_item(OP_SAMPLE, 10'd0);
      send_item(OP_PULLUP, 10'd1023);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_settings(MODE_DROP, 80, 850, 1000, 250, 3);
        1: load_settings(MODE_TURB, 0, 0, 0, 0, 1);
        2: load_settings(MODE_TURB, 1023, 1023, 1023, 1023, 7);
        3: load_settings(MODE_TURB, 0, 0, 0, 0, 0);
        4: load_settings(MODE_DROP, 1023, 1023, 1023, 1023, 0);
        5: load_settings(MODE_TURB, 150, 550, 1000, 250, 2);
        default: load_settings($urandom_range(0, 1), pick_threshold(), pick_threshold(),
                               pick_threshold(), pick_threshold(), $urandom_range(0, 7));
      endcase
      if (phase == 2) hold_off_req = 1'b1;
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) begin
        send_snapshot();
        if (phase == 3 && samples_sent - phase_start >= PHASE_ITEMS / 2 &&
            samples_sent - phase_start < PHASE_ITEMS / 2 + 10) begin
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d samples under %0d register settings in both modes",
             samples_sent, settings_used);
    $display("checked %0d results: %0d not connected, %0d suspect snapshots",
             checker_h.readings_seen, checker_h.disconnects_seen,
             checker_h.suspect_snapshots);
    if (checker_h.errors == 0) begin
      $display("analog_sensor_disconnect_qualifier_unit: match");
    end else begin
      $display("analog_sensor_disconnect_qualifier_unit: mismatch");
    end
    $finish;
  end

endmodule

### analog_sensor_disconnect_qualifier_unit.f
rtl/core/asdq_pkg.sv
rtl/core/asdq_regs.sv
rtl/core/asdq_eval.sv
rtl/core/analog_sensor_disconnect_qualifier_unit.sv
test/analog_sensor_disconnect_qualifier_unit_tb.sv
